@@ design/smx_pkg.sv @@
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants of the stack machine executor
// Holds the item structs, the opcode and fault codes, the controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package smx_pkg;

  // Stack geometry.
  localparam int StackDepth = 16;
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  // Fixed field widths.
  localparam int FuncW  = 8;
  localparam int ImmW   = 16;
  localparam int DataW  = 32;
  localparam int CountW = 5;

  typedef enum logic [FuncW-1:0] {
    OP_PUSH = 8'd0,
    OP_POP  = 8'd1,
    OP_DUP  = 8'd2,
    OP_SWAP = 8'd3,
    OP_CMP  = 8'd4,
    OP_ADD  = 8'd5,
    OP_MUL  = 8'd6,
    OP_JMP  = 8'd7,
    OP_JLE  = 8'd8
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_UNDERFLOW = 2'd1,
    FAULT_OVERFLOW  = 2'd2,
    FAULT_SWAPDEPTH = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WR1,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [FuncW-1:0]       func;
    logic signed [ImmW-1:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic signed [ImmW-1:0]  jump_offset;
    logic signed [DataW-1:0] top_value;
    logic [CountW-1:0]       stack_count;
    fault_e                  fault;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the item and read the two stack operands
    logic plan;    // evaluate the instruction and register its effects
    logic wr1;     // first stack write
    logic wr2;     // second stack write (swap only)
    logic commit;  // update the stack pointer and load the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

@@ design/smx_ctrl.sv @@
// ----------------------------------------------------------------------------
// smx_ctrl: instruction sequencer
// Steps each accepted item through operand read, evaluation, stack writes
// and result hand-off, and drives the input stall.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  smx_pkg::dp_status_t   status_i,
  output smx_pkg::ctrl_cmd_t    cmd_o
);

  smx_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      smx_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = smx_pkg::ST_EXEC;
        end
      end
      smx_pkg::ST_EXEC: begin
        cmd_o.plan = 1'b1;
        state_d    = smx_pkg::ST_WR1;
      end
      smx_pkg::ST_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = smx_pkg::ST_FIN;
      end
      smx_pkg::ST_FIN: begin
        // The second write repeats harmlessly while the output is blocked.
        cmd_o.wr2 = 1'b1;
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = smx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/smx_dp.sv @@
// ----------------------------------------------------------------------------
// smx_dp: stack datapath
// Holds the stack memory, the stack pointer, the instruction evaluation
// with its multiplier, and the output register.
// ----------------------------------------------------------------------------
module smx_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smx_pkg::in_item_t     in_item_i,
  input  smx_pkg::ctrl_cmd_t    cmd_i,
  output smx_pkg::dp_status_t   status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output smx_pkg::out_item_t    out_item_o
);

  localparam int SpW   = smx_pkg::SpW;
  localparam int AddrW = smx_pkg::AddrW;
  localparam int DataW = smx_pkg::DataW;
  localparam int ImmW  = smx_pkg::ImmW;

  logic [DataW-1:0] mem_q [smx_pkg::StackDepth];

  logic [SpW-1:0]            sp_q;
  logic [smx_pkg::FuncW-1:0] func_q;
  logic [ImmW-1:0]           imm_q;
  logic [DataW-1:0]          rd_top_q;  // entry at sp-1
  logic [DataW-1:0]          rd_sec_q;  // entry at sp-2, or at sp-1-depth for swap

  // Effects of the current instruction, registered in the evaluation cycle.
  logic                  w1_en_q, w1_en_d, w2_en_q, w2_en_d;
  logic [AddrW-1:0]      w1_addr_q, w1_addr_d, w2_addr_q, w2_addr_d;
  logic [DataW-1:0]      w1_data_q, w1_data_d, w2_data_q, w2_data_d;
  logic [SpW-1:0]        sp_new_q, sp_new_d;
  logic [ImmW-1:0]       jump_q, jump_d;
  logic [DataW-1:0]      top_q, top_d;
  smx_pkg::fault_e       fault_q, fault_d;

  logic                  out_valid_q;
  smx_pkg::out_item_t    out_item_q;

  logic [AddrW-1:0] addr_top, addr_sec;
  logic [ImmW-1:0]  sp_ext, sec_swap;
  logic [DataW-1:0] imm32, product, combined;
  logic             lt, gt;

  // Operand addresses come straight from the incoming item.
  assign sp_ext   = ImmW'(sp_q);
  assign sec_swap = sp_ext - ImmW'(1) - in_item_i.immediate;
  assign addr_top = AddrW'(sp_q - SpW'(1));
  assign addr_sec = (in_item_i.func == smx_pkg::OP_SWAP) ? sec_swap[AddrW-1:0]
                                                         : AddrW'(sp_q - SpW'(2));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= in_item_i.func;
      imm_q    <= in_item_i.immediate;
      rd_top_q <= mem_q[addr_top];
      rd_sec_q <= mem_q[addr_sec];
    end
    if (cmd_i.wr1 && w1_en_q) begin
      mem_q[w1_addr_q] <= w1_data_q;
    end else if (cmd_i.wr2 && w2_en_q) begin
      mem_q[w2_addr_q] <= w2_data_q;
    end
  end

  // Binary operations take second-from-top as the left operand.
  assign imm32   = {{(DataW - ImmW){imm_q[ImmW-1]}}, imm_q};
  assign product = rd_sec_q * rd_top_q;
  assign gt      = $signed(rd_sec_q) > $signed(rd_top_q);
  assign lt      = $signed(rd_sec_q) < $signed(rd_top_q);

  always_comb begin
    unique case (func_q)
      smx_pkg::OP_ADD: combined = rd_sec_q + rd_top_q;
      smx_pkg::OP_MUL: combined = product;
      default:         combined = gt ? DataW'(1) : (lt ? '1 : '0);
    endcase
  end

  always_comb begin
    fault_d   = smx_pkg::FAULT_NONE;
    sp_new_d  = sp_q;
    jump_d    = '0;
    top_d     = (sp_q != '0) ? rd_top_q : '0;
    w1_en_d   = 1'b0;
    w1_addr_d = AddrW'(sp_q - SpW'(1));
    w1_data_d = rd_sec_q;
    w2_en_d   = 1'b0;
    w2_addr_d = sp_ext[AddrW-1:0] - AddrW'(1) - imm_q[AddrW-1:0];
    w2_data_d = rd_top_q;
    unique case (func_q)
      smx_pkg::OP_PUSH: begin
        if (sp_q >= SpW'(smx_pkg::StackDepth)) begin
          fault_d = smx_pkg::FAULT_OVERFLOW;
        end else begin
          w1_en_d   = 1'b1;
          w1_addr_d = sp_q[AddrW-1:0];
          w1_data_d = imm32;
          sp_new_d  = sp_q + SpW'(1);
          top_d     = imm32;
        end
      end
      smx_pkg::OP_POP: begin
        if (sp_q < SpW'(1)) begin
          fault_d = smx_pkg::FAULT_UNDERFLOW;
        end else begin
          sp_new_d = sp_q - SpW'(1);
          top_d    = (sp_q >= SpW'(2)) ? rd_sec_q : '0;
        end
      end
      smx_pkg::OP_DUP: begin
        if (sp_q < SpW'(1)) begin
          fault_d = smx_pkg::FAULT_UNDERFLOW;
        end else if (sp_q >= SpW'(smx_pkg::StackDepth)) begin
          fault_d = smx_pkg::FAULT_OVERFLOW;
        end else begin
          w1_en_d   = 1'b1;
          w1_addr_d = sp_q[AddrW-1:0];
          w1_data_d = rd_top_q;
          sp_new_d  = sp_q + SpW'(1);
        end
      end
      smx_pkg::OP_SWAP: begin
        if (sp_q < SpW'(1)) begin
          fault_d = smx_pkg::FAULT_UNDERFLOW;
        end else if (imm_q[ImmW-1] || (imm_q >= sp_ext)) begin
          fault_d = smx_pkg::FAULT_SWAPDEPTH;
        end else begin
          // A depth of zero writes the top back onto itself.
          w1_en_d = 1'b1;
          w2_en_d = 1'b1;
          top_d   = rd_sec_q;
        end
      end
      smx_pkg::OP_CMP, smx_pkg::OP_ADD, smx_pkg::OP_MUL: begin
        if (sp_q < SpW'(2)) begin
          fault_d = smx_pkg::FAULT_UNDERFLOW;
        end else begin
          w1_en_d   = 1'b1;
          w1_addr_d = AddrW'(sp_q - SpW'(2));
          w1_data_d = combined;
          sp_new_d  = sp_q - SpW'(1);
          top_d     = combined;
        end
      end
      smx_pkg::OP_JMP: begin
        jump_d = imm_q;
      end
      smx_pkg::OP_JLE: begin
        if (sp_q < SpW'(1)) begin
          fault_d = smx_pkg::FAULT_UNDERFLOW;
        end else begin
          if ($signed(rd_top_q) < $signed(DataW'(1))) begin
            jump_d = imm_q;
          end
          sp_new_d = sp_q - SpW'(1);
          top_d    = (sp_q >= SpW'(2)) ? rd_sec_q : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      w1_addr_q <= w1_addr_d;
      w1_data_q <= w1_data_d;
      w2_addr_q <= w2_addr_d;
      w2_data_q <= w2_data_d;
      sp_new_q  <= sp_new_d;
      jump_q    <= jump_d;
      top_q     <= top_d;
      fault_q   <= fault_d;
    end
    if (cmd_i.commit) begin
      out_item_q.jump_offset <= jump_q;
      out_item_q.top_value   <= top_q;
      out_item_q.stack_count <= smx_pkg::CountW'(sp_new_q);
      out_item_q.fault       <= fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      w1_en_q     <= 1'b0;
      w2_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.plan) begin
        w1_en_q <= w1_en_d;
        w2_en_q <= w2_en_d;
      end
      if (cmd_i.commit) begin
        sp_q        <= sp_new_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;

endmodule

@@ design/stack_machine_executor.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor: one instruction of a 32-bit operand-stack machine
// Executes push, pop, dup, swap, compare, add, multiply and jumps on a
// sixteen-entry stack, returning jump offset, top value, depth and fault.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel carries one instruction item (opcode and signed 16-bit
// immediate) and the output channel carries exactly one result item per
// instruction, in order. Both channels use valid and stall; an item moves on a
// rising edge where valid is high and stall is low.
// An instruction is accepted and its two operands are read from the stack
// memory, then it is evaluated (this cycle holds the multiplier), then up to
// two stack writes go through the single memory write port. The result is
// registered into the output at commit, and the next item can be accepted
// once that commit is done, so the block takes no new item before the last
// is through. The single write port takes the two writes of a swap in turn.
// The output register decouples the two sides: a finished result may wait
// while the next item is already being read and evaluated. When the
// receiver stalls, the result holds steady and the sequencer waits at the
// commit step, so no result is lost or overwritten.
// Reset empties the stack at once; stack contents are not cleared and are
// only ever used after being written.
// ----------------------------------------------------------------------------
module stack_machine_executor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smx_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smx_pkg::out_item_t  out_item_o
);

  smx_pkg::ctrl_cmd_t  cmd;
  smx_pkg::dp_status_t status;

  // The sequencer owns the control flow and the input stall.
  smx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath owns the stack, the evaluation and the output register.
  smx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Once an item is taken, the block is busy with it in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous item still in flight");

  // A committed result is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  // A faulting instruction never takes a jump.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.fault != smx_pkg::FAULT_NONE))
      |-> (out_item_o.jump_offset == '0))
    else $error("jump reported with a fault");

  // The sequencer issues at most one of load, plan, wr1 and wr2 per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.plan, cmd.wr1, cmd.wr2}))
    else $error("overlapping sequencer commands");

endmodule

@@ tb/stack_machine_executor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_machine_executor_tb: self-checking bench for the stack executor
// A shadow stack predicts the result of every instruction the block takes.
// Results are checked in order, field by field. A short directed program
// comes first, then biased random instructions, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module stack_machine_executor_tb;
  import smx_pkg::*;

  // Random instruction count after the directed program.
  localparam int unsigned RandomItems = 1600;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned HangLimit = 2000;
  // Length of the one long receiver hold-off, and when it starts.
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter  = 400;

  // Stimulus phases bias the opcode mix so that the stack both fills up to
  // overflow and drains down to underflow.
  typedef enum int unsigned {
    PH_GROW,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;

  stack_machine_executor i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // --------------------------------------------------------------------------
  // Shadow stack. It mirrors the stack words and the entry count, works out
  // the result of each accepted instruction and keeps those results in order
  // until the block delivers them.
  // --------------------------------------------------------------------------
  class stack_shadow;
    logic [DataW-1:0] words [StackDepth];
    int unsigned      entries;
    out_item_t        expected_results [$];
    int unsigned      mismatches;

    function new();
      entries    = 0;
      mismatches = 0;
    endfunction

    function int unsigned depth();
      return entries;
    endfunction

    function int unsigned waiting();
      return expected_results.size();
    endfunction

    // Applies one instruction to the shadow state and queues its result.
    function void note_instruction(in_item_t it);
      logic [DataW-1:0] imm_ext;
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      logic [DataW-1:0] held;
      logic [ImmW-1:0]  jump;
      fault_e           flt;
      int unsigned      n;
      int unsigned      swap_depth;
      out_item_t        res;

      imm_ext    = {{(DataW - ImmW){it.immediate[ImmW-1]}}, it.immediate};
      swap_depth = {16'b0, it.immediate};
      jump       = '0;
      flt        = FAULT_NONE;
      n          = entries;

      case (it.func)
        OP_PUSH: begin
          if (n >= StackDepth) begin
            flt = FAULT_OVERFLOW;
          end else begin
            words[n] = imm_ext;
            n++;
          end
        end
        OP_POP: begin
          if (n < 1) flt = FAULT_UNDERFLOW;
          else n--;
        end
        OP_DUP: begin
          if (n < 1) begin
            flt = FAULT_UNDERFLOW;
          end else if (n >= StackDepth) begin
            flt = FAULT_OVERFLOW;
          end else begin
            words[n] = words[n-1];
            n++;
          end
        end
        OP_SWAP: begin
          // Depth counts down from the top; zero leaves the stack as it is.
          if (n < 1) begin
            flt = FAULT_UNDERFLOW;
          end else if (it.immediate[ImmW-1] || swap_depth >= n) begin
            flt = FAULT_SWAPDEPTH;
          end else begin
            held                  = words[n-1];
            words[n-1]            = words[n-1-swap_depth];
            words[n-1-swap_depth] = held;
          end
        end
        OP_CMP, OP_ADD, OP_MUL: begin
          // Second-from-top is the left operand, the top the right one.
          if (n < 2) begin
            flt = FAULT_UNDERFLOW;
          end else begin
            a = words[n-2];
            b = words[n-1];
            if (it.func == OP_ADD) words[n-2] = a + b;
            else if (it.func == OP_MUL) words[n-2] = a * b;
            else if ($signed(a) > $signed(b)) words[n-2] = 32'd1;
            else if ($signed(a) < $signed(b)) words[n-2] = 32'hFFFF_FFFF;
            else words[n-2] = 32'd0;
            n--;
          end
        end
        OP_JMP: begin
          jump = it.immediate;
        end
        OP_JLE: begin
          // The top is popped whether or not the jump is taken.
          if (n < 1) begin
            flt = FAULT_UNDERFLOW;
          end else begin
            if ($signed(words[n-1]) < 1) jump = it.immediate;
            n--;
          end
        end
        default: begin
        end
      endcase

      entries           = n;
      res.jump_offset   = jump;
      res.top_value     = (n > 0) ? words[n-1] : '0;
      res.stack_count   = n[CountW-1:0];
      res.fault         = flt;
      expected_results.push_back(res);
    endfunction

    // Compares one delivered result with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;

      if (expected_results.size() == 0) begin
        $display("%0t: result with no instruction pending, top %0d count %0d",
                 $time, got.top_value, got.stack_count);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.jump_offset !== want.jump_offset) begin
        $display("%0t: jump_offset expected %0d, actual %0d",
                 $time, want.jump_offset, got.jump_offset);
        mismatches++;
      end
      if (got.top_value !== want.top_value) begin
        $display("%0t: top_value expected %0d, actual %0d",
                 $time, want.top_value, got.top_value);
        mismatches++;
      end
      if (got.stack_count !== want.stack_count) begin
        $display("%0t: stack_count expected %0d, actual %0d",
                 $time, want.stack_count, got.stack_count);
        mismatches++;
      end
      if (got.fault !== want.fault) begin
        $display("%0t: fault expected %0d, actual %0d",
                 $time, want.fault, got.fault);
        mismatches++;
      end
    endfunction
  endclass

  stack_shadow shadow = new();

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Builds an instruction item from an opcode byte and a raw immediate.
  function automatic in_item_t instr(logic [FuncW-1:0] f, logic [ImmW-1:0] imm);
    in_item_t it;
    it.func      = f;
    it.immediate = imm;
    return it;
  endfunction

  // Idle length before an item: mostly none or short, now and then long.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Draws one instruction. The phase sets the opcode mix; swap depths are
  // mostly drawn around the current entry count so that both legal and
  // out-of-range depths come up often.
  function automatic in_item_t random_instruction(phase_e phase, int unsigned n);
    int unsigned      weights [3][10] = '{
      '{45, 15,  8,  6,  6,  6,  3, 3,  4, 4},
      '{ 8,  4, 10, 12, 10, 10, 14, 4, 20, 8},
      '{22, 10, 14,  8,  8,  8,  8, 6, 10, 6}
    };
    op_e              kinds [9] = '{OP_PUSH, OP_DUP, OP_SWAP, OP_CMP, OP_ADD,
                                    OP_MUL, OP_POP, OP_JMP, OP_JLE};
    logic [ImmW-1:0]  corners [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                      16'h0001};
    int unsigned      r;
    int unsigned      acc;
    int unsigned      k;
    logic [FuncW-1:0] f;
    logic [ImmW-1:0]  imm;

    r   = $urandom_range(0, 99);
    acc = 0;
    for (k = 0; k < 9; k++) begin
      acc += weights[int'(phase)][k];
      if (r < acc) break;
    end
    // Index nine is noise: opcodes the block must ignore.
    f   = (k >= 9) ? FuncW'($urandom_range(OP_JLE + 1, 255)) : kinds[k];
    imm = ImmW'($urandom);
    if (f == OP_PUSH && $urandom_range(0, 9) == 0) begin
      imm = corners[$urandom_range(0, 4)];
    end else if (f == OP_SWAP && $urandom_range(0, 5) != 0) begin
      imm = ImmW'($urandom_range(0, n));
    end
    return instr(f, imm);
  endfunction

  // Offers one item after an idle gap and returns at the edge that takes it.
  // Valid only drops when there is a gap, so back-to-back items keep it high.
  task automatic send_instruction(in_item_t it, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.note_instruction(it);
  endtask

  // Result side: every item taken by the bench is checked at once.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      shadow.check_result(out_item_o);
      results_seen++;
    end
  end

  // Receiver stalls. Short stalls dominate, with a few long ones and long
  // free-flowing stretches. Once, well into the run, the receiver holds off
  // long enough for the block to fill and push back on the sender.
  initial begin
    bit          hold_done;
    int unsigned len;

    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (len - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
        repeat (len - 1) @(posedge clk_i);
      end
    end
  end

  // Hang detection: any stretch without a handshake on either side that
  // reaches the limit ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= HangLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, HangLimit, shadow.waiting());
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence: reset, directed program, random program, drain, verdict.
  initial begin
    in_item_t    program_q [$];
    phase_e      phase;
    int unsigned phase_left;
    bit          steady;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed program. Every underflow case on an empty stack, a jump and
    // an unknown opcode first, then bad swap depths, all compare outcomes, a
    // taken and a not-taken conditional jump, and an add that wraps.
    program_q.push_back(instr(OP_POP,  16'h0000));
    program_q.push_back(instr(OP_DUP,  16'h0000));
    program_q.push_back(instr(OP_SWAP, 16'h0000));
    program_q.push_back(instr(OP_CMP,  16'h0000));
    program_q.push_back(instr(OP_ADD,  16'h0000));
    program_q.push_back(instr(OP_MUL,  16'h0000));
    program_q.push_back(instr(OP_JLE,  16'd100));
    program_q.push_back(instr(OP_JMP,  16'h8000));
    program_q.push_back(instr(8'hFF,   16'hFFFF));
    program_q.push_back(instr(OP_PUSH, 16'h7FFF));
    program_q.push_back(instr(OP_ADD,  16'h0000));
    program_q.push_back(instr(OP_SWAP, 16'h0001));
    program_q.push_back(instr(OP_PUSH, 16'h8000));
    program_q.push_back(instr(OP_SWAP, 16'hFFFF));
    program_q.push_back(instr(OP_SWAP, 16'h0001));
    program_q.push_back(instr(OP_CMP,  16'h0000));
    program_q.push_back(instr(OP_DUP,  16'h0000));
    program_q.push_back(instr(OP_CMP,  16'h0000));
    program_q.push_back(instr(OP_JLE,  16'd5));
    program_q.push_back(instr(OP_PUSH, 16'h0001));
    program_q.push_back(instr(OP_PUSH, 16'h0000));
    program_q.push_back(instr(OP_CMP,  16'h0000));
    program_q.push_back(instr(OP_JLE,  16'hFFF9));
    program_q.push_back(instr(OP_PUSH, 16'h8000));
    program_q.push_back(instr(OP_DUP,  16'h0000));
    program_q.push_back(instr(OP_MUL,  16'h0000));
    program_q.push_back(instr(OP_DUP,  16'h0000));
    program_q.push_back(instr(OP_ADD,  16'h0000));
    program_q.push_back(instr(OP_SWAP, 16'h0000));
    foreach (program_q[i]) send_instruction(program_q[i], gap_length());

    // Random program in phases of random length. Some phases run without
    // any sender gaps at all.
    phase      = PH_GROW;
    phase_left = 0;
    steady     = 1'b0;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (phase_left == 0) begin
        phase      = phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 40);
        steady     = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      send_instruction(random_instruction(phase, shadow.depth()),
                       steady ? 0 : gap_length());
    end
    in_valid_i <= 1'b0;

    // Drain, then allow a few more cycles for any stray result to show up.
    while (shadow.waiting() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/smx_pkg.sv
design/smx_ctrl.sv
design/smx_dp.sv
design/stack_machine_executor.sv
tb/stack_machine_executor_tb.sv
